@@ rtl/ppc_pkg.sv @@
package ppc_pkg;

   localparam int MaxVerticesDefault = 16;
   localparam int MaxResults         = 32;
   localparam int CoordW             = 32;
   localparam int TagW               = 8;
   localparam int DistW              = 68;
   localparam int TW                 = 31;
   localparam logic [TW-1:0] TOne    = 31'h4000_0000;

   localparam logic [2:0] CsrNormX  = 3'd0;
   localparam logic [2:0] CsrNormY  = 3'd1;
   localparam logic [2:0] CsrNormZ  = 3'd2;
   localparam logic [2:0] CsrOffset = 3'd3;
   localparam logic [2:0] CsrEps    = 3'd4;
   localparam logic [2:0] CsrEdge   = 3'd5;
   localparam logic [2:0] CsrFace   = 3'd6;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic [TagW-1:0]          edge_a;
      logic [TagW-1:0]          face_a;
      logic [TagW-1:0]          edge_b;
      logic [TagW-1:0]          face_b;
   } vtx_type;

   // shared multiply-accumulate request
   typedef struct packed {
      logic                     clear;
      logic                     acc;
      logic signed [CoordW:0]   a;
      logic signed [CoordW:0]   b;
   } mac_ctl_type;

endpackage

@@ rtl/ppc_mac.sv @@
module ppc_mac
   import ppc_pkg::*;
(
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   output logic signed [DistW-1:0]  sum
);
   logic signed [2*CoordW+1:0] prod_ff, prod_in;
   logic signed [DistW-1:0]    sum_ff, sum_in;
   logic                       acc_ff;

   always_comb begin
      prod_in = ctl.a * ctl.b;
      sum_in  = ctl.clear ? '0 : sum_ff;
      if (acc_ff) begin
         sum_in = sum_ff + DistW'(prod_ff);
      end
      if (ctl.clear) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= ctl.acc;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;
endmodule

@@ rtl/ppc_div.sv @@
module ppc_div
   import ppc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [TW-1:0]  num,
   input  logic [TW-1:0]  den,
   output logic           done,
   output logic [TW-1:0]  quo
);
   // restoring divide, one quotient bit a cycle; num < den
   logic [TW:0]   rem_ff, rem_in;
   logic [TW-1:0] q_ff, q_in, d_ff;
   logic [4:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [TW+1:0] sh;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      sh = {rem_ff, 1'b0};
      if (go) begin
         rem_in = {1'b0, num}; q_in = '0; cnt_in = 5'd30; run_in = 1'b1;
      end else if (run_ff) begin
         if (sh >= {2'b0, d_ff}) begin
            rem_in = (TW+1)'(sh - {2'b0, d_ff});
            q_in   = {q_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = sh[TW:0];
            q_in   = {q_ff[TW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (go) begin
         d_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

@@ rtl/polygon_plane_clipper_unit.sv @@
// Operation: a vertex that is not last is stored. The last vertex starts a clip
// that measures the closing vertex, then each stored vertex, runs the divider and
// three serial lerp multiplies per crossing edge (only the lerp multiplies when
// the ratio clamps) and ends with a flush. A result leaves the cycle after
// the next one is produced, the final one at the flush. Throughput: one polygon
// at a time, busy meanwhile. Reset: synchronous, active high; no result stalls.
module polygon_plane_clipper_unit
   import ppc_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [7:0]         req_tag_edge_a,
   input  logic [7:0]         req_tag_face_a,
   input  logic [7:0]         req_tag_edge_b,
   input  logic [7:0]         req_tag_face_b,
   input  logic               req_is_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [7:0]         rsp_out_edge_a,
   output logic [7:0]         rsp_out_face_a,
   output logic [7:0]         rsp_out_edge_b,
   output logic [7:0]         rsp_out_face_b,
   output logic               rsp_out_last,
   output logic               rsp_all_clipped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int IdxW = $clog2(MAX_VERTICES);
   localparam int CntW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_READ  = 9'b000000010,
      S_DIST  = 9'b000000100,
      S_DWAIT = 9'b000001000,
      S_DECIDE= 9'b000010000,
      S_DIV   = 9'b000100000,
      S_LERP  = 9'b001000000,
      S_EMITB = 9'b010000000,
      S_FLUSH = 9'b100000000
   } state_type;

   // configuration registers
   logic signed [31:0] nx_ff, ny_ff, nz_ff, off_ff;
   logic [30:0]        eps_ff;
   logic [7:0]         cedge_ff, cface_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= '0; ny_ff <= '0; nz_ff <= 32'sd65536; off_ff <= '0;
         eps_ff <= 31'd66; cedge_ff <= '0; cface_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrNormX:  nx_ff    <= csr_data;
            CsrNormY:  ny_ff    <= csr_data;
            CsrNormZ:  nz_ff    <= csr_data;
            CsrOffset: off_ff   <= csr_data;
            CsrEps:    eps_ff   <= csr_data[30:0];
            CsrEdge:   cedge_ff <= csr_data[7:0];
            CsrFace:   cface_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end
   // hold off register writes while a clip reads them
   assign csr_ready = !busy;

   // vertex store: one write port, one registered read port
   vtx_type           mem [MAX_VERTICES];
   vtx_type           rd_ff;
   logic [IdxW-1:0]   rd_addr;
   logic              wr_en;

   state_type         st_ff, st_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;     // stored vertices
   logic [CntW-1:0]   i_ff, i_in;         // edge index, CntW so it can reach cnt
   logic              first_ff, first_in; // computing A's distance
   logic [1:0]        ax_ff, ax_in;       // axis step for dot / lerp
   logic [2:0]        w_ff, w_in;         // wait counter
   vtx_type           va_ff, va_in, vb_ff, vb_in;
   logic signed [DistW-1:0] da_ff, da_in, db_ff, db_in;
   logic [TW-1:0]     t_ff, t_in;
   logic signed [31:0] ic_ff [3];
   logic signed [31:0] ic_in [3];
   logic [5:0]        n_ff, n_in;         // results emitted

   // pending output register (one result delayed so out_last can be set)
   logic              pv_ff, pv_in;
   vtx_type           pd_ff, pd_in;
   logic              ov_ff, ov_in, olast_ff, olast_in, oclip_ff, oclip_in;
   vtx_type           od_ff, od_in;

   assign wr_en = start && !busy && (cnt_ff < CntW'(MAX_VERTICES));
   assign busy  = (st_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[IdxW-1:0]] <= {req_pos_x, req_pos_y, req_pos_z, req_tag_edge_a,
                                   req_tag_face_a, req_tag_edge_b, req_tag_face_b};
      end
      rd_ff <= mem[rd_addr];
   end

   // shared multiplier
   mac_ctl_type             mctl;
   logic signed [DistW-1:0] msum;
   ppc_mac u_mac (.clock(clock), .ctl(mctl), .sum(msum));

   // divider for the crossing ratio
   logic          dgo, ddone;
   logic [TW-1:0] dnum, dden, dquo;
   ppc_div u_div (.clock(clock), .reset(reset), .go(dgo), .num(dnum), .den(dden),
                  .done(ddone), .quo(dquo));

   // crossing operands: halve until divisor below 2^31 (priority shift)
   logic signed [DistW-1:0] dens;
   logic [DistW-1:0]        anum, aden;
   logic                    tzero, tone;
   logic [6:0]              shamt;
   always_comb begin
      dens  = da_ff - db_ff;
      anum  = da_ff[DistW-1] ? DistW'(-da_ff) : DistW'(da_ff);
      aden  = dens[DistW-1] ? DistW'(-dens) : DistW'(dens);
      tzero = (dens == '0) || (!da_ff[DistW-1] && da_ff != '0 && dens[DistW-1])
              || (da_ff[DistW-1] && !dens[DistW-1] && dens != '0);
      tone  = anum >= aden;
      shamt = '0;
      for (int k = 31; k < DistW; k++) begin
         if (aden[k]) shamt = 7'(k - 30);
      end
      dnum = TW'((anum >> shamt) << 0);
      dden = TW'(aden >> shamt);
   end

   function automatic logic signed [31:0] axis(input vtx_type v, input logic [1:0] k);
      case (k)
         2'd0:    axis = v.x;
         2'd1:    axis = v.y;
         default: axis = v.z;
      endcase
   endfunction

   logic signed [32:0] diff;
   logic signed [DistW-1:0] lr;
   logic signed [31:0] nsel;
   logic ain, bin;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; i_in = i_ff; first_in = first_ff;
      ax_in = ax_ff; w_in = w_ff; va_in = va_ff; vb_in = vb_ff;
      da_in = da_ff; db_in = db_ff; t_in = t_ff; n_in = n_ff;
      ic_in = ic_ff;
      pv_in = pv_ff; pd_in = pd_ff;
      ov_in = 1'b0; olast_in = 1'b0; oclip_in = 1'b0; od_in = pd_ff;
      mctl = '0; dgo = 1'b0;
      rd_addr = i_ff[IdxW-1:0];
      ain = da_ff < $signed({37'd0, eps_ff});
      bin = db_ff < $signed({37'd0, eps_ff});
      diff = axis(vb_ff, ax_ff) - axis(va_ff, ax_ff);
      nsel = (ax_ff == 2'd0) ? nx_ff : (ax_ff == 2'd1) ? ny_ff : nz_ff;
      lr = '0;

      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               if (wr_en) cnt_in = cnt_ff + 1'b1;
               if (req_is_last) begin
                  if (cnt_in == '0) begin
                     st_in = S_FLUSH;
                  end else begin
                     i_in = cnt_in - 1'b1; first_in = 1'b1; st_in = S_READ;
                  end
                  n_in = '0;
               end
            end
         end
         S_READ: begin
            st_in = S_DIST; ax_in = '0;
         end
         S_DIST: begin
            // clear the sum on the first axis, then accumulate three products
            if (ax_ff == 2'd0) begin
               vb_in = rd_ff; mctl.clear = 1'b1;
            end
            mctl.a   = 33'(axis(ax_ff == 2'd0 ? rd_ff : vb_ff, ax_ff));
            mctl.b   = 33'(nsel);
            mctl.acc = 1'b1;
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               st_in = S_DWAIT; w_in = 3'd2;
            end
         end
         S_DWAIT: begin
            w_in = w_ff - 3'd1;
            if (w_ff == 3'd0) begin
               // distance is the floor of sum / 2^16 minus the offset
               db_in = (msum >>> 16) - DistW'(off_ff);
               st_in = S_DECIDE;
               if (first_ff) begin
                  first_in = 1'b0; i_in = '0;
               end
            end
         end
         S_DECIDE: begin
            // first time through, B holds the closing vertex: make it A
            if (i_ff == '0 && ax_ff == 2'd3) begin
               va_in = vb_ff; da_in = db_ff; st_in = S_READ;
               ax_in = '0;
            end else if (ain != bin) begin
               if (tzero) begin
                  t_in = '0; st_in = S_LERP; ax_in = '0; w_in = '0;
               end else if (tone) begin
                  t_in = TOne; st_in = S_LERP; ax_in = '0; w_in = '0;
               end else begin
                  dgo = 1'b1; st_in = S_DIV;
               end
            end else begin
               st_in = S_EMITB;
            end
         end
         S_DIV: begin
            if (ddone) begin
               t_in = dquo; st_in = S_LERP; ax_in = '0; w_in = '0;
            end
         end
         S_LERP: begin
            // each axis steps through issue, product, sum and capture
            mctl.a = 33'(diff); mctl.b = 33'({1'b0, t_ff});
            mctl.clear = (w_ff == 3'd0); mctl.acc = (w_ff == 3'd0);
            w_in = w_ff + 3'd1;
            if (w_ff == 3'd3) begin
               lr = DistW'(axis(va_ff, ax_ff)) + (msum >>> 30);
               if (lr > 68'sd2147483647) ic_in[ax_ff] = 32'sh7fffffff;
               else if (lr < -68'sd2147483648) ic_in[ax_ff] = 32'sh80000000;
               else ic_in[ax_ff] = lr[31:0];
               w_in = '0; ax_in = ax_ff + 2'd1;
               if (ax_ff == 2'd2) begin
                  pv_in = 1'b1; ov_in = pv_ff;
                  pd_in.x = ic_in[0]; pd_in.y = ic_in[1]; pd_in.z = ic_in[2];
                  if (bin) begin
                     pd_in.edge_a = cedge_ff; pd_in.face_a = cface_ff;
                     pd_in.edge_b = vb_ff.edge_a; pd_in.face_b = vb_ff.face_a;
                  end else begin
                     pd_in.edge_a = vb_ff.edge_a; pd_in.face_a = vb_ff.face_a;
                     pd_in.edge_b = cedge_ff; pd_in.face_b = cface_ff;
                  end
                  if (n_ff >= 6'(MaxResults)) begin
                     pv_in = pv_ff; pd_in = pd_ff; ov_in = 1'b0;
                  end else begin
                     n_in = n_ff + 6'd1;
                  end
                  st_in = S_EMITB;
               end
            end
         end
         S_EMITB: begin
            if (bin && n_ff < 6'(MaxResults)) begin
               pv_in = 1'b1; ov_in = pv_ff; pd_in = vb_ff; n_in = n_ff + 6'd1;
            end
            va_in = vb_ff; da_in = db_ff;
            i_in  = i_ff + 1'b1;
            if (i_in == cnt_ff) begin
               st_in = S_FLUSH;
            end else begin
               st_in = S_READ; ax_in = '0;
            end
            rd_addr = i_in[IdxW-1:0];
         end
         S_FLUSH: begin
            // drain the held result with the last mark, or report empty
            ov_in = 1'b1;
            if (pv_ff) begin
               olast_in = 1'b1;
            end else begin
               oclip_in = 1'b1; od_in = '0;
            end
            pv_in = 1'b0; cnt_in = '0; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_READ && first_ff) ax_in = 2'd0;
   end

   // the closing vertex pass marks itself with ax = 3 on entry to decide
   logic [1:0] ax_fix;
   always_comb begin
      ax_fix = ax_in;
      if (st_ff == S_DWAIT && w_ff == 3'd0 && first_ff) ax_fix = 2'd3;
      else if (st_ff == S_DWAIT && w_ff == 3'd0) ax_fix = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; pv_ff <= 1'b0; ov_ff <= 1'b0;
         i_ff <= '0; first_ff <= 1'b0; ax_ff <= '0; w_ff <= '0; n_ff <= '0;
         olast_ff <= 1'b0; oclip_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; pv_ff <= pv_in; ov_ff <= ov_in;
         i_ff <= i_in; first_ff <= first_in; ax_ff <= ax_fix; w_ff <= w_in;
         n_ff <= n_in; olast_ff <= olast_in; oclip_ff <= oclip_in;
      end
      va_ff <= va_in; vb_ff <= vb_in; da_ff <= da_in; db_ff <= db_in;
      t_ff <= t_in; pd_ff <= pd_in; od_ff <= od_in; ic_ff <= ic_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_x       = od_ff.x;
   assign rsp_out_y       = od_ff.y;
   assign rsp_out_z       = od_ff.z;
   assign rsp_out_edge_a  = od_ff.edge_a;
   assign rsp_out_face_a  = od_ff.face_a;
   assign rsp_out_edge_b  = od_ff.edge_b;
   assign rsp_out_face_b  = od_ff.face_b;
   assign rsp_out_last    = olast_ff;
   assign rsp_all_clipped = oclip_ff;

   // last and empty never together
   a_last_clip: assert property (@(posedge clock) disable iff (reset)
      !(rsp_out_last && rsp_all_clipped)) else $error("last with empty flag");
   // empty report carries zero x and edge_a
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_all_clipped |-> (rsp_out_x == '0 && rsp_out_edge_a == '0))
      else $error("empty result not zero");
   // store count stays in range
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MAX_VERTICES)) else $error("vertex count overflow");
endmodule
